### rtl/core/chd_pkg.sv
package chd_pkg;

    localparam int CNT_W = 21;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] MAX_TOTAL_RESET = 21'd524288;

    // configuration register map
    localparam int ADDR_W = 3;
    localparam logic REG_MAX_TOTAL = 1'b0;

    // parse phases
    localparam logic [2:0] PH_WS     = 3'd0;
    localparam logic [2:0] PH_NUM    = 3'd1;
    localparam logic [2:0] PH_REST   = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_POST   = 3'd4;
    localparam logic [2:0] PH_POSTCR = 3'd5;

    // result status codes
    localparam logic [2:0] ST_RUN       = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_BIG       = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    // characters
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef struct packed {
        logic [2:0]       phase;
        logic [CNT_W-1:0] size;
        logic             digits;
        logic             nonblank;
        logic             bad;
        logic [CNT_W-1:0] decoded;
        logic             stopped;
    } state_t;

    typedef struct packed {
        logic       produce;
        logic       emit;
        logic [2:0] status;
    } res_t;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = '0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, c[3:0]};
            end
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            begin
                r = {1'b1, c[3:0] + 4'd9};
            end
            return r;
        end
    endfunction

endpackage

### rtl/core/chd_step.sv
module chd_step #(
    parameter int LINE_MAX = 64
) (
    input  chd_pkg::state_t                  cur,
    input  logic [$clog2(LINE_MAX)-1:0]      cur_len,
    input  logic [7:0]                       c,
    input  logic                             last,
    input  logic [chd_pkg::CNT_W-1:0]        max_total,
    output chd_pkg::state_t                  nxt,
    output logic [$clog2(LINE_MAX)-1:0]      nxt_len,
    output chd_pkg::res_t                    res,
    output logic [chd_pkg::CNT_W-1:0]        total
);

    localparam int LW = $clog2(LINE_MAX);
    localparam logic [LW-1:0] LEN_TOP = LW'(LINE_MAX - 1);

    logic [4:0]                     hd;
    logic                           ws;
    logic                           blank_ch;
    logic [chd_pkg::CNT_W+3:0]      acc;
    logic [chd_pkg::CNT_W:0]        sum;
    logic [2:0]                     stat;
    logic                           emit;

    assign hd       = chd_pkg::hex_digit(c);
    assign blank_ch = (c == chd_pkg::CH_SP) || (c == chd_pkg::CH_TAB) || (c == chd_pkg::CH_CR);
    assign ws       = blank_ch || (c == chd_pkg::CH_VT) || (c == chd_pkg::CH_FF);
    assign acc      = {cur.size, hd[3:0]};
    assign sum      = {1'b0, cur.decoded} + {1'b0, cur.size};

    always_comb
    begin
        nxt     = cur;
        nxt_len = cur_len;
        stat    = chd_pkg::ST_RUN;
        emit    = 1'b0;
        total   = cur.decoded;
        if (cur.stopped)
        begin
            if (last)
            begin
                nxt     = '0;
                nxt_len = '0;
            end
        end
        else
        begin
            if (cur.phase == chd_pkg::PH_DATA && cur.size != '0)
            begin
                // payload byte
                emit = 1'b1;
                if (cur.decoded != chd_pkg::CNT_MAX)
                begin
                    nxt.decoded = cur.decoded + 1'b1;
                end
                nxt.size = cur.size - 1'b1;
                if (cur.size == chd_pkg::CNT_W'(1))
                begin
                    nxt.phase = chd_pkg::PH_POST;
                end
            end
            else if ((cur.phase == chd_pkg::PH_POST &&
                      (c == chd_pkg::CH_CR || c == chd_pkg::CH_LF)) ||
                     (cur.phase == chd_pkg::PH_POSTCR && c == chd_pkg::CH_LF))
            begin
                // optional crlf after payload
                if (c == chd_pkg::CH_CR)
                begin
                    nxt.phase = chd_pkg::PH_POSTCR;
                end
                else
                begin
                    nxt.phase    = chd_pkg::PH_WS;
                    nxt.size     = '0;
                    nxt.digits   = 1'b0;
                    nxt.nonblank = 1'b0;
                    nxt.bad      = 1'b0;
                    nxt_len      = '0;
                end
            end
            else
            begin
                // size line byte; a phase past the line restarts it
                if (cur.phase > chd_pkg::PH_REST)
                begin
                    nxt.phase    = chd_pkg::PH_WS;
                    nxt.size     = '0;
                    nxt.digits   = 1'b0;
                    nxt.nonblank = 1'b0;
                    nxt.bad      = 1'b0;
                    nxt_len      = '0;
                end
                if (c == chd_pkg::CH_LF)
                begin
                    // end of size line, fields here are fresh when phase was past the line
                    if (nxt.bad)
                    begin
                        stat = chd_pkg::ST_MALFORMED;
                    end
                    else if (!nxt.nonblank)
                    begin
                        nxt.phase  = chd_pkg::PH_WS;
                        nxt.size   = '0;
                        nxt.digits = 1'b0;
                        nxt_len    = '0;
                    end
                    else if (!nxt.digits)
                    begin
                        stat = chd_pkg::ST_MALFORMED;
                    end
                    else if (nxt.size == '0)
                    begin
                        stat = (cur.decoded != '0) ? chd_pkg::ST_OK : chd_pkg::ST_EMPTY;
                    end
                    else if (last)
                    begin
                        stat = chd_pkg::ST_TRUNC;
                    end
                    else if (sum > {1'b0, max_total})
                    begin
                        stat = chd_pkg::ST_BIG;
                    end
                    else
                    begin
                        nxt.phase    = chd_pkg::PH_DATA;
                        nxt.digits   = 1'b0;
                        nxt.nonblank = 1'b0;
                        nxt.bad      = 1'b0;
                        nxt_len      = '0;
                    end
                end
                else
                begin
                    if (nxt_len == LEN_TOP)
                    begin
                        nxt.bad = 1'b1;
                    end
                    else
                    begin
                        nxt_len = nxt_len + 1'b1;
                    end
                    if (!blank_ch)
                    begin
                        nxt.nonblank = 1'b1;
                    end
                    if (nxt.phase == chd_pkg::PH_NUM)
                    begin
                        if (hd[4])
                        begin
                            nxt.size = (acc[chd_pkg::CNT_W+3:chd_pkg::CNT_W] != '0) ?
                                       chd_pkg::CNT_MAX : acc[chd_pkg::CNT_W-1:0];
                        end
                        else
                        begin
                            nxt.phase = chd_pkg::PH_REST;
                        end
                    end
                    else if (nxt.phase != chd_pkg::PH_REST)
                    begin
                        nxt.phase = chd_pkg::PH_WS;
                        if (hd[4])
                        begin
                            nxt.size   = chd_pkg::CNT_W'(hd[3:0]);
                            nxt.digits = 1'b1;
                            nxt.phase  = chd_pkg::PH_NUM;
                        end
                        else if (!ws)
                        begin
                            nxt.bad   = 1'b1;
                            nxt.phase = chd_pkg::PH_REST;
                        end
                    end
                end
            end

            if (stat == chd_pkg::ST_RUN && last)
            begin
                if (nxt.phase == chd_pkg::PH_DATA || nxt_len != '0)
                begin
                    stat = chd_pkg::ST_TRUNC;
                end
                else
                begin
                    stat = (nxt.decoded != '0) ? chd_pkg::ST_OK : chd_pkg::ST_EMPTY;
                end
            end

            total = nxt.decoded;
            if (stat != chd_pkg::ST_RUN)
            begin
                if (last)
                begin
                    nxt     = '0;
                    nxt_len = '0;
                end
                else
                begin
                    nxt.stopped = 1'b1;
                end
            end
        end
        res.produce = emit || (stat != chd_pkg::ST_RUN);
        res.emit    = emit;
        res.status  = stat;
    end

endmodule

### rtl/core/http_chunked_body_decoder.sv
// channel  | handshake              | payload
// ---------+------------------------+--------------------------------------------------
// input    | in_valid / in_ready    | in_byte, in_last
// result   | res_valid / res_ready  | out_byte, out_valid, finished, status, payload_total
// config   | apb psel/penable/pwrite| paddr, pwdata, prdata (max_total at address 0)
//
// one body byte per cycle sustained while res_ready stays high; each byte is
// held in an input register, decoded by the single-pass next-state logic and
// its result lands in the result register
// a byte that gives no result still moves through the input register
// rst_n clears the parse state, both valid flags and sets max_total to 524288
// with res_ready low the input register still takes one more byte, then
// in_ready drops until the result register empties
module http_chunked_body_decoder #(
    parameter int LINE_MAX = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [chd_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // body bytes in
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        in_byte,
    input  logic                              in_last,
    // results out
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [7:0]                        out_byte,
    output logic                              out_valid,
    output logic                              finished,
    output logic [2:0]                        status,
    output logic [chd_pkg::CNT_W-1:0]         payload_total
);

    localparam int LW = $clog2(LINE_MAX);

    // configuration
    logic [chd_pkg::CNT_W-1:0] max_total_reg;
    logic                      cfg_wr;

    // input register
    logic       in_full_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parse state
    chd_pkg::state_t  st_reg;
    chd_pkg::state_t  st_next;
    logic [LW-1:0]    len_reg;
    logic [LW-1:0]    len_next;

    // step result
    chd_pkg::res_t             res;
    logic [chd_pkg::CNT_W-1:0] total;

    // result register
    logic                      res_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      out_valid_reg;
    logic                      finished_reg;
    logic [2:0]                status_reg;
    logic [chd_pkg::CNT_W-1:0] total_reg;

    logic adv;

    // apb: writes land on the access phase, only register 0 exists
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == chd_pkg::REG_MAX_TOTAL);
    assign prdata = (paddr[2] == chd_pkg::REG_MAX_TOTAL) ?
                    {{(32-chd_pkg::CNT_W){1'b0}}, max_total_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_total_reg <= chd_pkg::MAX_TOTAL_RESET;
        end
        else if (cfg_wr)
        begin
            max_total_reg <= pwdata[chd_pkg::CNT_W-1:0];
        end
    end

    // the held byte moves on once the result register has room
    assign adv      = in_full_reg && (!res_valid_reg || res_ready);
    assign in_ready = !in_full_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

    chd_step #(
        .LINE_MAX (LINE_MAX)
    ) u_step (
        .cur       (st_reg),
        .cur_len   (len_reg),
        .c         (in_byte_reg),
        .last      (in_last_reg),
        .max_total (max_total_reg),
        .nxt       (st_next),
        .nxt_len   (len_next),
        .res       (res),
        .total     (total)
    );

    // parse state advances with each byte decoded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= '0;
            len_reg <= '0;
        end
        else if (adv)
        begin
            st_reg  <= st_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= res.produce;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg  <= res.emit ? in_byte_reg : 8'd0;
            out_valid_reg <= res.emit;
            finished_reg  <= (res.status != chd_pkg::ST_RUN);
            status_reg    <= res.status;
            total_reg     <= total;
        end
    end

    assign res_valid     = res_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_valid     = out_valid_reg;
    assign finished      = finished_reg;
    assign status        = status_reg;
    assign payload_total = total_reg;

    // a finished result always carries a final status
    a_fin_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && finished_reg |-> status_reg != chd_pkg::ST_RUN)
        else $error("finished result with running status");

    // every result carries a byte or an end of body
    a_res_content: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> out_valid_reg || finished_reg)
        else $error("empty result");

    // bytes after the end of decoding give no result
    a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        adv && st_reg.stopped |=> !res_valid_reg)
        else $error("result after decoding stopped");

    // a held byte is kept while the result side stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && !adv |=> in_full_reg)
        else $error("input byte lost while stalled");

endmodule
